@@ sv/sio_hp_pkg.sv @@
// Types and constants shared by the header parser files.
`default_nettype none

package sio_hp_pkg;

   localparam logic [3:0] PH_MAGIC     = 4'd0;
   localparam logic [3:0] PH_LINES     = 4'd1;
   localparam logic [3:0] PH_ELEMENTS  = 4'd2;
   localparam logic [3:0] PH_TYPE      = 4'd3;
   localparam logic [3:0] PH_SIZE      = 4'd4;
   localparam logic [3:0] PH_COUNT     = 4'd5;
   localparam logic [3:0] PH_IDLEN     = 4'd6;
   localparam logic [3:0] PH_IDBYTES   = 4'd7;
   localparam logic [3:0] PH_DATALEN   = 4'd8;
   localparam logic [3:0] PH_DATABYTES = 4'd9;
   localparam logic [3:0] PH_DONE      = 4'd10;
   localparam logic [3:0] PH_ERROR     = 4'd11;

   localparam logic [3:0] KIND_VERSION   = 4'd0;
   localparam logic [3:0] KIND_LINES     = 4'd1;
   localparam logic [3:0] KIND_ELEMENTS  = 4'd2;
   localparam logic [3:0] KIND_TYPE      = 4'd3;
   localparam logic [3:0] KIND_SIZE      = 4'd4;
   localparam logic [3:0] KIND_COUNT     = 4'd5;
   localparam logic [3:0] KIND_ID_LEN    = 4'd6;
   localparam logic [3:0] KIND_ID_BYTE   = 4'd7;
   localparam logic [3:0] KIND_DATA_LEN  = 4'd8;
   localparam logic [3:0] KIND_DATA_BYTE = 4'd9;
   localparam logic [3:0] KIND_BAD_MAGIC = 4'd10;

   localparam logic [7:0] MAGIC_MARK   = 8'hFF;
   localparam logic [7:0] MAGIC_ANCHOR = 8'h7F;
   localparam logic [7:0] MIN_VERSION  = 8'd2;

   typedef struct packed {
      logic [3:0]  phase;
      logic [1:0]  byte_pos;
      logic [23:0] partial;
      logic        little_endian;
      logic [7:0]  version;
      logic [30:0] entries_left;
      logic [30:0] bytes_left;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase: PH_MAGIC, byte_pos: 2'd0, partial: 24'd0, little_endian: 1'b0,
      version: 8'd0, entries_left: 31'd0, bytes_left: 31'd0};

   typedef struct packed {
      logic [3:0]         kind;
      logic signed [31:0] value;
      logic               little_endian;
      logic               last_of_run;
      logic               null_term;
      logic               complete;
   } result_type;

endpackage

`default_nettype wire

@@ sv/sio_hp_if.sv @@
// Request and response channel interfaces of the header parser.
`default_nettype none

interface sio_hp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       start_of_stream;

   modport source (output valid, output byte_value, output start_of_stream, input ready);
   modport sink (input valid, input byte_value, input start_of_stream, output ready);
endinterface

interface sio_hp_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         field_kind;
   logic signed [31:0] field_value;
   logic               file_little_endian;
   logic               last_of_run;
   logic               id_null_terminated;
   logic               header_complete;

   modport source (output valid, output field_kind, output field_value,
                   output file_little_endian, output last_of_run,
                   output id_null_terminated, output header_complete, input ready);
   modport sink (input valid, input field_kind, input field_value,
                 input file_little_endian, input last_of_run,
                 input id_null_terminated, input header_complete, output ready);
endinterface

`default_nettype wire

@@ sv/sio_hp_decode.sv @@
// Per-byte parse step: next parser state and the result for one header byte.
`default_nettype none

module sio_hp_decode (
   input  wire sio_hp_pkg::state_type  state_cur,
   input  wire logic [7:0]             byte_value,
   input  wire logic                   start_of_stream,
   output sio_hp_pkg::state_type       state_in,
   output logic                        emit,
   output sio_hp_pkg::result_type      result
);

   sio_hp_pkg::state_type st;
   logic [31:0] word;
   logic [31:0] value;
   logic [30:0] count;
   logic [30:0] bytes_dec;
   logic [30:0] entries_dec;
   logic        last;
   logic [7:0]  mb0;
   logic [7:0]  mb1;
   logic [7:0]  mb2;
   logic [7:0]  mb3;

   always_comb begin
      st          = start_of_stream ? sio_hp_pkg::STATE_RESET : state_cur;
      state_in    = st;
      emit        = 1'b0;
      result      = '0;
      word        = {st.partial, byte_value};
      mb0         = word[31:24];
      mb1         = word[23:16];
      mb2         = word[15:8];
      mb3         = word[7:0];
      value       = st.little_endian ? {mb3, mb2, mb1, mb0} : word;
      count       = value[31] ? 31'd0 : value[30:0];
      bytes_dec   = (st.bytes_left != 31'd0) ? st.bytes_left - 31'd1 : 31'd0;
      entries_dec = (st.entries_left != 31'd0) ? st.entries_left - 31'd1 : 31'd0;
      last        = (bytes_dec == 31'd0);

      if (st.phase == sio_hp_pkg::PH_DONE || st.phase >= sio_hp_pkg::PH_ERROR) begin
         emit = 1'b0;
      end else if (st.phase == sio_hp_pkg::PH_IDBYTES ||
                   st.phase == sio_hp_pkg::PH_DATABYTES) begin
         emit                = 1'b1;
         state_in.bytes_left = bytes_dec;
         result.value        = {24'd0, byte_value};
         result.last_of_run  = last;
         if (st.phase == sio_hp_pkg::PH_IDBYTES) begin
            result.kind      = sio_hp_pkg::KIND_ID_BYTE;
            result.null_term = last && (byte_value == 8'd0);
            if (last) begin
               state_in.phase = sio_hp_pkg::PH_DATALEN;
            end
         end else begin
            result.kind = sio_hp_pkg::KIND_DATA_BYTE;
            if (last) begin
               state_in.entries_left = entries_dec;
               if (entries_dec == 31'd0) begin
                  state_in.phase  = sio_hp_pkg::PH_DONE;
                  result.complete = 1'b1;
               end else begin
                  state_in.phase = sio_hp_pkg::PH_IDLEN;
               end
            end
         end
      end else if (st.byte_pos != 2'd3) begin
         state_in.partial  = {st.partial[15:0], byte_value};
         state_in.byte_pos = st.byte_pos + 2'd1;
      end else begin
         emit              = 1'b1;
         state_in.partial  = 24'd0;
         state_in.byte_pos = 2'd0;
         result.value      = value;
         unique case (st.phase)
            sio_hp_pkg::PH_MAGIC: begin
               if (mb0 == sio_hp_pkg::MAGIC_MARK && mb2 == sio_hp_pkg::MAGIC_ANCHOR &&
                   (mb1 ^ mb3) == sio_hp_pkg::MAGIC_MARK) begin
                  state_in.little_endian = 1'b0;
                  state_in.version       = mb1;
                  state_in.phase         = sio_hp_pkg::PH_LINES;
                  result.kind            = sio_hp_pkg::KIND_VERSION;
                  result.value           = {24'd0, mb1};
               end else if (mb3 == sio_hp_pkg::MAGIC_MARK &&
                            mb1 == sio_hp_pkg::MAGIC_ANCHOR &&
                            (mb0 ^ mb2) == sio_hp_pkg::MAGIC_MARK) begin
                  state_in.little_endian = 1'b1;
                  state_in.version       = mb2;
                  state_in.phase         = sio_hp_pkg::PH_LINES;
                  result.kind            = sio_hp_pkg::KIND_VERSION;
                  result.value           = {24'd0, mb2};
               end else begin
                  state_in.little_endian = 1'b0;
                  state_in.phase         = sio_hp_pkg::PH_ERROR;
                  result.kind            = sio_hp_pkg::KIND_BAD_MAGIC;
                  result.value           = word;
               end
            end
            sio_hp_pkg::PH_LINES: begin
               state_in.phase = sio_hp_pkg::PH_ELEMENTS;
               result.kind    = sio_hp_pkg::KIND_LINES;
            end
            sio_hp_pkg::PH_ELEMENTS: begin
               state_in.phase = sio_hp_pkg::PH_TYPE;
               result.kind    = sio_hp_pkg::KIND_ELEMENTS;
            end
            sio_hp_pkg::PH_TYPE: begin
               state_in.phase = sio_hp_pkg::PH_SIZE;
               result.kind    = sio_hp_pkg::KIND_TYPE;
            end
            sio_hp_pkg::PH_SIZE: begin
               result.kind = sio_hp_pkg::KIND_SIZE;
               if (st.version >= sio_hp_pkg::MIN_VERSION) begin
                  state_in.phase = sio_hp_pkg::PH_COUNT;
               end else begin
                  state_in.phase  = sio_hp_pkg::PH_DONE;
                  result.complete = 1'b1;
               end
            end
            sio_hp_pkg::PH_COUNT: begin
               result.kind           = sio_hp_pkg::KIND_COUNT;
               state_in.entries_left = count;
               if (count == 31'd0) begin
                  state_in.phase  = sio_hp_pkg::PH_DONE;
                  result.complete = 1'b1;
               end else begin
                  state_in.phase = sio_hp_pkg::PH_IDLEN;
               end
            end
            sio_hp_pkg::PH_IDLEN: begin
               result.kind         = sio_hp_pkg::KIND_ID_LEN;
               state_in.bytes_left = count;
               state_in.phase      = (count == 31'd0) ? sio_hp_pkg::PH_DATALEN
                                                      : sio_hp_pkg::PH_IDBYTES;
            end
            default: begin
               result.kind         = sio_hp_pkg::KIND_DATA_LEN;
               state_in.bytes_left = count;
               if (count != 31'd0) begin
                  state_in.phase = sio_hp_pkg::PH_DATABYTES;
               end else begin
                  state_in.entries_left = entries_dec;
                  if (entries_dec == 31'd0) begin
                     state_in.phase  = sio_hp_pkg::PH_DONE;
                     result.complete = 1'b1;
                  end else begin
                     state_in.phase = sio_hp_pkg::PH_IDLEN;
                  end
               end
            end
         endcase
      end
      result.little_endian = state_in.little_endian;
   end

endmodule

`default_nettype wire

@@ sv/sio_header_parser.sv @@
// Top level of the stream image header parser.
// Takes one header byte per request and returns at most one response per byte,
// sustaining one byte every cycle while responses are taken. A request is held in an input
// register, and parse logic between it and the response register updates the parser state
// and fills the response register as the byte leaves the input register. A byte that
// gives a response waits in the input register while an untaken response is held, and
// holds back the next request. Bytes that give no response (the first three bytes of each
// 32-bit word, and all bytes after the header or after a bad magic word) are consumed
// silently. A request with start_of_stream set restarts parsing at that byte.
`default_nettype none

module sio_header_parser (
   input wire logic clock,
   input wire logic reset,
   sio_hp_req_if.sink   req_bus,
   sio_hp_rsp_if.source rsp_bus
);

   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_sos_ff;
   sio_hp_pkg::state_type  state_ff;
   sio_hp_pkg::state_type  state_in;
   logic                   out_valid_ff;
   sio_hp_pkg::result_type out_ff;
   sio_hp_pkg::result_type result;
   logic                   emit;
   logic                   advance;

   sio_hp_decode u_decode (
      .state_cur       (state_ff),
      .byte_value      (in_byte_ff),
      .start_of_stream (in_sos_ff),
      .state_in        (state_in),
      .emit            (emit),
      .result          (result)
   );

   assign advance       = in_valid_ff && (!emit || !out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.byte_value;
         in_sos_ff  <= req_bus.start_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sio_hp_pkg::STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid              = out_valid_ff;
   assign rsp_bus.field_kind         = out_ff.kind;
   assign rsp_bus.field_value        = out_ff.value;
   assign rsp_bus.file_little_endian = out_ff.little_endian;
   assign rsp_bus.last_of_run        = out_ff.last_of_run;
   assign rsp_bus.id_null_terminated = out_ff.null_term;
   assign rsp_bus.header_complete    = out_ff.complete;

`ifndef SYNTHESIS
   a_complete_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.complete |->
         out_ff.kind == sio_hp_pkg::KIND_SIZE || out_ff.kind == sio_hp_pkg::KIND_COUNT ||
         out_ff.kind == sio_hp_pkg::KIND_DATA_LEN ||
         out_ff.kind == sio_hp_pkg::KIND_DATA_BYTE)
      else $error("header complete on a field that cannot end the header");

   a_null_term: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.null_term |->
         out_ff.last_of_run && out_ff.kind == sio_hp_pkg::KIND_ID_BYTE &&
         out_ff.value == 32'sd0)
      else $error("null termination flagged on a non-final or nonzero id byte");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.last_of_run |->
         out_ff.kind == sio_hp_pkg::KIND_ID_BYTE || out_ff.kind == sio_hp_pkg::KIND_DATA_BYTE)
      else $error("last of run flagged outside a byte run");

   a_bad_magic_order: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == sio_hp_pkg::KIND_BAD_MAGIC |-> !out_ff.little_endian)
      else $error("byte order reported after a bad magic word");

   a_stall_no_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && emit && out_valid_ff && !rsp_bus.ready |=> $stable(state_ff))
      else $error("parser state moved while the response register was blocked");
`endif

endmodule

`default_nettype wire

@@ tb/tb_sio_header_parser.sv @@
// Self-checking testbench for the header parser: random header streams, stalls and checks.
`default_nettype none

module tb_sio_header_parser;

   localparam int BYTE_TARGET = 500;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;

   class header_decode;
      logic [3:0]  phase;
      logic [1:0]  byte_pos;
      logic [23:0] partial;
      logic        little_endian;
      logic [7:0]  version;
      logic [30:0] entries_left;
      logic [30:0] bytes_left;
      sio_hp_pkg::result_type pending_fields[$];
      int          errors;

      function new();
         errors = 0;
         restart();
      endfunction

      function void restart();
         phase = sio_hp_pkg::PH_MAGIC;
         byte_pos = 2'd0;
         partial = 24'd0;
         little_endian = 1'b0;
         version = 8'd0;
         entries_left = 31'd0;
         bytes_left = 31'd0;
      endfunction

      function int pending();
         return pending_fields.size();
      endfunction

      function void add_field(logic [3:0] kind, logic [31:0] value, logic last,
                              logic nullt, logic done);
         sio_hp_pkg::result_type f;
         f.kind = kind;
         f.value = value;
         f.little_endian = little_endian;
         f.last_of_run = last;
         f.null_term = nullt;
         f.complete = done;
         pending_fields.insert(pending_fields.size(), f);
      endfunction

      function logic [30:0] as_count(logic [31:0] v);
         return v[31] ? 31'd0 : v[30:0];
      endfunction

      // Close one user-data entry; return 1 when the header is complete.
      function logic close_entry();
         if (entries_left > 0) entries_left = entries_left - 31'd1;
         if (entries_left == 0) begin
            phase = sio_hp_pkg::PH_DONE;
            return 1'b1;
         end
         phase = sio_hp_pkg::PH_IDLEN;
         return 1'b0;
      endfunction

      // Advance on one accepted request; return 1 unless the byte is dropped.
      function bit take_byte(logic [7:0] b, logic sos);
         logic [31:0] w;
         logic [31:0] v;
         logic        last;
         logic        done;
         if (sos) restart();
         if (phase == sio_hp_pkg::PH_DONE || phase >= sio_hp_pkg::PH_ERROR) return 1'b0;
         if (phase == sio_hp_pkg::PH_IDBYTES || phase == sio_hp_pkg::PH_DATABYTES) begin
            if (bytes_left > 0) bytes_left = bytes_left - 31'd1;
            last = (bytes_left == 0);
            if (phase == sio_hp_pkg::PH_IDBYTES) begin
               add_field(sio_hp_pkg::KIND_ID_BYTE, {24'd0, b}, last, last && b == 8'd0,
                         1'b0);
               if (last) phase = sio_hp_pkg::PH_DATALEN;
            end else begin
               done = last ? close_entry() : 1'b0;
               add_field(sio_hp_pkg::KIND_DATA_BYTE, {24'd0, b}, last, 1'b0, done);
            end
            return 1'b1;
         end
         if (byte_pos < 2'd3) begin
            partial = {partial[15:0], b};
            byte_pos = byte_pos + 2'd1;
            return 1'b1;
         end
         w = {partial, b};
         byte_pos = 2'd0;
         partial = 24'd0;
         if (phase == sio_hp_pkg::PH_MAGIC) begin
            if (w[31:24] == sio_hp_pkg::MAGIC_MARK && w[15:8] == sio_hp_pkg::MAGIC_ANCHOR
                && (w[23:16] ^ w[7:0]) == 8'hFF) begin
               little_endian = 1'b0;
               version = w[23:16];
            end else if (w[7:0] == sio_hp_pkg::MAGIC_MARK
                         && w[23:16] == sio_hp_pkg::MAGIC_ANCHOR
                         && (w[31:24] ^ w[15:8]) == 8'hFF) begin
               little_endian = 1'b1;
               version = w[15:8];
            end else begin
               little_endian = 1'b0;
               phase = sio_hp_pkg::PH_ERROR;
               add_field(sio_hp_pkg::KIND_BAD_MAGIC, w, 1'b0, 1'b0, 1'b0);
               return 1'b1;
            end
            phase = sio_hp_pkg::PH_LINES;
            add_field(sio_hp_pkg::KIND_VERSION, {24'd0, version}, 1'b0, 1'b0, 1'b0);
            return 1'b1;
         end
         v = little_endian ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
         done = 1'b0;
         case (phase)
            sio_hp_pkg::PH_LINES: begin
               phase = sio_hp_pkg::PH_ELEMENTS;
               add_field(sio_hp_pkg::KIND_LINES, v, 1'b0, 1'b0, 1'b0);
            end
            sio_hp_pkg::PH_ELEMENTS: begin
               phase = sio_hp_pkg::PH_TYPE;
               add_field(sio_hp_pkg::KIND_ELEMENTS, v, 1'b0, 1'b0, 1'b0);
            end
            sio_hp_pkg::PH_TYPE: begin
               phase = sio_hp_pkg::PH_SIZE;
               add_field(sio_hp_pkg::KIND_TYPE, v, 1'b0, 1'b0, 1'b0);
            end
            sio_hp_pkg::PH_SIZE: begin
               if (version >= sio_hp_pkg::MIN_VERSION) begin
                  phase = sio_hp_pkg::PH_COUNT;
               end else begin
                  phase = sio_hp_pkg::PH_DONE;
                  done = 1'b1;
               end
               add_field(sio_hp_pkg::KIND_SIZE, v, 1'b0, 1'b0, done);
            end
            sio_hp_pkg::PH_COUNT: begin
               entries_left = as_count(v);
               if (entries_left == 0) begin
                  phase = sio_hp_pkg::PH_DONE;
                  done = 1'b1;
               end else begin
                  phase = sio_hp_pkg::PH_IDLEN;
               end
               add_field(sio_hp_pkg::KIND_COUNT, v, 1'b0, 1'b0, done);
            end
            sio_hp_pkg::PH_IDLEN: begin
               bytes_left = as_count(v);
               phase = (bytes_left == 0) ? sio_hp_pkg::PH_DATALEN : sio_hp_pkg::PH_IDBYTES;
               add_field(sio_hp_pkg::KIND_ID_LEN, v, 1'b0, 1'b0, 1'b0);
            end
            default: begin
               bytes_left = as_count(v);
               if (bytes_left == 0) done = close_entry();
               else phase = sio_hp_pkg::PH_DATABYTES;
               add_field(sio_hp_pkg::KIND_DATA_LEN, v, 1'b0, 1'b0, done);
            end
         endcase
         return 1'b1;
      endfunction

      function void compare_field(sio_hp_pkg::result_type got);
         sio_hp_pkg::result_type exp;
         if (pending_fields.size() == 0) begin
            $error("unexpected response: kind %0d value %h", got.kind, got.value);
            errors++;
            return;
         end
         exp = pending_fields.pop_front();
         if (got.kind !== exp.kind) begin
            $error("field_kind: expected %0d, actual %0d", exp.kind, got.kind);
            errors++;
         end
         if (got.value !== exp.value) begin
            $error("field_value: expected %h, actual %h", exp.value, got.value);
            errors++;
         end
         if (got.little_endian !== exp.little_endian) begin
            $error("file_little_endian: expected %b, actual %b",
                   exp.little_endian, got.little_endian);
            errors++;
         end
         if (got.last_of_run !== exp.last_of_run) begin
            $error("last_of_run: expected %b, actual %b", exp.last_of_run, got.last_of_run);
            errors++;
         end
         if (got.null_term !== exp.null_term) begin
            $error("id_null_terminated: expected %b, actual %b",
                   exp.null_term, got.null_term);
            errors++;
         end
         if (got.complete !== exp.complete) begin
            $error("header_complete: expected %b, actual %b", exp.complete, got.complete);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   sio_hp_req_if req_bus();
   sio_hp_rsp_if rsp_bus();

   sio_header_parser DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   header_decode fields = new();
   logic [7:0]   stream_bytes[$];
   bit           quiet;
   int           stall_left;
   int           cycle_count;
   int           bytes_taken;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(negedge clock) begin
      sio_hp_pkg::result_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.kind = rsp_bus.field_kind;
         got.value = rsp_bus.field_value;
         got.little_endian = rsp_bus.file_little_endian;
         got.last_of_run = rsp_bus.last_of_run;
         got.null_term = rsp_bus.id_null_terminated;
         got.complete = rsp_bus.header_complete;
         fields.compare_field(got);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sio_header_parser test failed");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] b, logic sos);
      int  gap;
      bit  fire;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.byte_value <= b;
      req_bus.start_of_stream <= sos;
      forever begin
         @(negedge clock);
         fire = (req_bus.ready === 1'b1);
         @(posedge clock);
         if (fire) break;
      end
      if (fields.take_byte(b, sos)) bytes_taken++;
   endtask

   task automatic play_stream();
      for (int i = 0; i < stream_bytes.size(); i++) send_byte(stream_bytes[i], i == 0);
      stream_bytes.delete();
   endtask

   // Hold requests until every pending response is back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (fields.pending() > 0);
   endtask

   function void put_byte(logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
   endfunction

   function void add_word(logic [31:0] v, bit le);
      if (le) begin
         put_byte(v[7:0]);
         put_byte(v[15:8]);
         put_byte(v[23:16]);
         put_byte(v[31:24]);
      end else begin
         put_byte(v[31:24]);
         put_byte(v[23:16]);
         put_byte(v[15:8]);
         put_byte(v[7:0]);
      end
   endfunction

   function void add_magic(logic [7:0] ver, bit le);
      if (le) add_word({~ver, sio_hp_pkg::MAGIC_ANCHOR, ver, sio_hp_pkg::MAGIC_MARK}, 1'b0);
      else add_word({sio_hp_pkg::MAGIC_MARK, ver, sio_hp_pkg::MAGIC_ANCHOR, ~ver}, 1'b0);
   endfunction

   function logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'h7FFF_FFFF;
         3: return 32'h8000_0000;
         4: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function logic [31:0] rand_len(int max_len);
      if ($urandom_range(0, 9) == 0) return 32'h8000_0000 | $urandom;
      return $urandom_range(0, max_len);
   endfunction

   function logic [7:0] rand_version();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd2;
         3: return 8'd3;
         4: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function void build_header();
      logic [7:0]  ver;
      logic [31:0] cnt;
      logic [31:0] id_len;
      logic [31:0] data_len;
      bit          le;
      int          n;
      ver = rand_version();
      le = 1'($urandom_range(0, 1));
      add_magic(ver, le);
      repeat (4) add_word(rand_word(), le);
      if (ver >= sio_hp_pkg::MIN_VERSION) begin
         cnt = rand_len(3);
         add_word(cnt, le);
         n = cnt[31] ? 0 : int'(cnt);
         repeat (n) begin
            id_len = rand_len(4);
            add_word(id_len, le);
            if (!id_len[31]) begin
               for (int k = 0; k < id_len; k++) begin
                  if (k == id_len - 1 && $urandom_range(0, 1))
                     put_byte(8'd0);
                  else
                     put_byte(8'($urandom_range(0, 255)));
               end
            end
            data_len = rand_len(5);
            add_word(data_len, le);
            if (!data_len[31])
               repeat (data_len) put_byte(8'($urandom_range(0, 255)));
         end
      end
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
   endfunction

   function void build_stream();
      int r;
      int cut;
      int k;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         build_header();
      end else if (r < 83) begin
         add_magic(rand_version(), 1'($urandom_range(0, 1)));
         k = $urandom_range(0, 3);
         stream_bytes[k] = stream_bytes[k] ^ (8'd1 << $urandom_range(0, 7));
         repeat ($urandom_range(0, 4)) put_byte(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
         build_header();
         cut = $urandom_range(1, stream_bytes.size());
         while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
      end else begin
         repeat ($urandom_range(1, 12)) put_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   initial begin
      reset = 1'b1;
      quiet = 1'b0;
      bytes_taken = 0;
      req_bus.valid = 1'b0;
      req_bus.byte_value = 8'd0;
      req_bus.start_of_stream = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Big-endian version 2 with extreme fields and a negative entry count.
      add_magic(8'd2, 1'b0);
      add_word(32'h7FFF_FFFF, 1'b0);
      add_word(32'h8000_0000, 1'b0);
      add_word(32'h0000_0000, 1'b0);
      add_word(32'hFFFF_FFFF, 1'b0);
      add_word(32'hFFFF_FFFF, 1'b0);
      play_stream();
      // Bad magic word, then a byte that must be dropped.
      add_word(32'h1234_5678, 1'b0);
      put_byte(8'hFF);
      play_stream();
      drain();

      while (bytes_taken < BYTE_TARGET) begin
         quiet = ($urandom_range(0, 4) == 0);
         build_stream();
         play_stream();
         if ($urandom_range(0, 9) == 0) drain();
      end
      quiet = 1'b0;

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fields.errors == 0 && fields.pending() == 0) begin
         $display("sio_header_parser test passed");
      end else begin
         $display("sio_header_parser test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
sv/sio_hp_pkg.sv
sv/sio_hp_if.sv
sv/sio_hp_decode.sv
sv/sio_header_parser.sv
tb/tb_sio_header_parser.sv
